// ===== rtl/grid_cell_compaction_neighbors_unit_assert.svh =====
// Assertion macros for the checker file of the grid compaction unit.
`ifndef GRID_CELL_COMPACTION_NEIGHBORS_UNIT_ASSERT_SVH
`define GRID_CELL_COMPACTION_NEIGHBORS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GCCN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GCCN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gccn_pkg.sv =====
// Shared constants, types and helper functions of the grid compaction unit.
package gccn_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int MAX_NODES  = 4096;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int CELLS      = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = NODE_W + 1;
  localparam int DIM_W      = 7;
  localparam int NBR_MAX    = 4;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;
  localparam int CFG_ADDR_W = 1;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_CELL  = 2'd1;
  localparam logic [1:0] REQ_COORD = 2'd2;
  localparam logic [1:0] REQ_NBR   = 2'd3;

  typedef struct packed {
    logic [1:0]        req;
    logic              start;
    logic              blocked;
    logic [SIDE_W-1:0] qx;
    logic [SIDE_W-1:0] qy;
    logic [NODE_W-1:0] node;
  } cmd_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    return (r > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : r;
  endfunction

  // Neighbor order +x, -x, +y, -y; a step of -1 is all ones.
  function automatic logic [DIM_W-1:0] step_x(input logic [1:0] k);
    logic [DIM_W-1:0] s;
    unique case (k)
      2'd0:    s = DIM_W'(1);
      2'd1:    s = '1;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [DIM_W-1:0] step_y(input logic [1:0] k);
    logic [DIM_W-1:0] s;
    unique case (k)
      2'd2:    s = DIM_W'(1);
      2'd3:    s = '1;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/gccn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gccn_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gccn_front.sv =====
// Input side: takes request transfers, decodes them and queues them for the back end.
module gccn_front
  import gccn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 hold,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // cell_blocked[0], query_x[6:1], query_y[12:7], query_node[24:13], zero[31:25]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // req_type[1:0], grid_start[2]
  input  logic [IN_USER_W-1:0] in_tuser,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  cmd_t              cmd_in;
  logic              push, pop;

  always_comb begin
    cmd_in.req     = in_tuser[1:0];
    cmd_in.start   = in_tuser[2];
    cmd_in.blocked = in_tdata[0];
    cmd_in.qx      = in_tdata[6:1];
    cmd_in.qy      = in_tdata[12:7];
    cmd_in.node    = in_tdata[24:13];
  end

  assign in_tready = (cnt_r != (QPTR_W+1)'(QDEPTH)) && !hold;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== rtl/gccn_back.sv =====
// Execution side: loads cells, runs lookups and neighbor scans, and drives the result stream.
module gccn_back
  import gccn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [DIM_W-1:0]      grid_w,
  input  logic [DIM_W-1:0]      grid_h,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  clearing,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_CELL  = 4'd3;
  localparam logic [3:0] S_NODE  = 4'd4;
  localparam logic [3:0] S_COORD = 4'd5;
  localparam logic [3:0] S_NBR   = 4'd6;
  localparam logic [3:0] S_P0    = 4'd7;
  localparam logic [3:0] S_P1    = 4'd8;
  localparam logic [3:0] S_P2    = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]            state_r, state_nxt;
  logic [CELL_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]      node_count_r, node_count_nxt;
  logic [SIDE_W-1:0]     load_x_r, load_x_nxt;
  logic [DIM_W-1:0]      load_y_r, load_y_nxt;
  logic [1:0]            emit_idx_r, emit_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;

  cmd_t                  cmd_r, cmd_nxt;
  logic [SIDE_W-1:0]     cx_r, cx_nxt, cy_r, cy_nxt;
  logic [1:0]            k_r, k_nxt;
  logic [CELL_W-1:0]     probe_addr_r, probe_addr_nxt;
  logic                  pass_r, pass_nxt;
  logic [NODE_W-1:0]     probe_id_r, probe_id_nxt;
  logic [2:0]            hits_r, hits_nxt;
  logic [NODE_W-1:0]     res_node_r [NBR_MAX];
  logic [NODE_W-1:0]     res_node_nxt [NBR_MAX];
  logic [2:0]            res_n_r, res_n_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [SIDE_W-1:0]     res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic                  res_ovf_r, res_ovf_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  fm_q;
  logic [NODE_W-1:0]     noc_q;
  logic [CELL_W-1:0]     con_q;
  logic                  fm_we, fm_wd;
  logic [CELL_W-1:0]     fm_waddr;
  logic                  ld_we;
  logic [CELL_W-1:0]     ld_cell;
  logic [NODE_W-1:0]     ld_id;
  logic [NODE_W-1:0]     con_raddr;

  logic [SIDE_W-1:0]     lx;
  logic [DIM_W-1:0]      ly;
  logic [CNT_W-1:0]      lcnt;
  logic                  ld_outside;
  logic [DIM_W-1:0]      nx, ny;
  logic                  nbr_inb, cell_inb, hit, nbr_adv, out_free, emit_last;
  logic [2:0]            hits_cnt;

  gccn_ram #(.WIDTH(1), .DEPTH(CELLS)) u_free_map (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wd),
    .raddr(probe_addr_r), .rdata(fm_q)
  );

  gccn_ram #(.WIDTH(NODE_W), .DEPTH(CELLS)) u_node_of_cell (
    .clk(clk), .we(ld_we), .waddr(ld_cell), .wdata(ld_id),
    .raddr(probe_addr_r), .rdata(noc_q)
  );

  gccn_ram #(.WIDTH(CELL_W), .DEPTH(MAX_NODES)) u_cell_of_node (
    .clk(clk), .we(ld_we), .waddr(ld_id), .wdata(ld_cell),
    .raddr(con_raddr), .rdata(con_q)
  );

  assign clearing   = (state_r == S_CLEAR);
  assign cmd_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    lx         = cmd_r.start ? '0 : load_x_r;
    ly         = cmd_r.start ? '0 : load_y_r;
    lcnt       = cmd_r.start ? '0 : node_count_r;
    ld_outside = ({1'b0, lx} >= grid_w) || (ly >= grid_h);
    ld_cell    = {ly[SIDE_W-1:0], lx};
    ld_id      = lcnt[NODE_W-1:0];
    ld_we      = (state_r == S_LOAD) && !ld_outside && !cmd_r.blocked
                 && (lcnt < CNT_W'(MAX_NODES));
    fm_we      = clearing || ld_we;
    fm_waddr   = clearing ? clr_addr_r : ld_cell;
    fm_wd      = !clearing;
    con_raddr  = (state_r == S_P1) ? noc_q : cmd_r.node;
    nx         = {1'b0, cx_r} + step_x(k_r);
    ny         = {1'b0, cy_r} + step_y(k_r);
    nbr_inb    = (nx < grid_w) && (ny < grid_h);
    cell_inb   = ({1'b0, cmd_r.qx} < grid_w) && ({1'b0, cmd_r.qy} < grid_h);
    hit        = pass_r && (con_q == probe_addr_r);
    out_free   = !out_valid_r || out_tready;
    emit_last  = ({1'b0, emit_idx_r} + 3'd1) == res_n_r;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    node_count_nxt = node_count_r;
    load_x_nxt     = load_x_r;
    load_y_nxt     = load_y_r;
    emit_idx_nxt   = emit_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    cmd_nxt        = cmd_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    k_nxt          = k_r;
    probe_addr_nxt = probe_addr_r;
    pass_nxt       = pass_r;
    probe_id_nxt   = probe_id_r;
    hits_nxt       = hits_r;
    res_node_nxt   = res_node_r;
    res_n_nxt      = res_n_r;
    res_found_nxt  = res_found_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_ovf_nxt    = res_ovf_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;
    nbr_adv        = 1'b0;
    hits_cnt       = hits_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd;
          unique case (cmd.req)
            REQ_LOAD:  state_nxt = S_LOAD;
            REQ_CELL:  state_nxt = S_CELL;
            REQ_COORD: state_nxt = S_NODE;
            REQ_NBR:   state_nxt = S_NODE;
          endcase
        end
      end
      S_LOAD: begin
        res_n_nxt       = 3'd1;
        res_x_nxt       = '0;
        res_y_nxt       = '0;
        res_found_nxt   = 1'b0;
        res_ovf_nxt     = 1'b0;
        res_node_nxt[0] = '0;
        node_count_nxt  = lcnt;
        load_x_nxt      = lx;
        load_y_nxt      = ly;
        if (ld_outside) begin
          res_ovf_nxt = 1'b1;
        end else begin
          if (ld_we) begin
            res_found_nxt   = 1'b1;
            res_node_nxt[0] = ld_id;
            node_count_nxt  = lcnt + 1'b1;
          end else if (!cmd_r.blocked) begin
            res_ovf_nxt = 1'b1;
          end
          if (({1'b0, lx} + 1'b1) >= grid_w) begin
            load_x_nxt = '0;
            load_y_nxt = ly + 1'b1;
          end else begin
            load_x_nxt = lx + 1'b1;
          end
        end
        state_nxt = S_EMIT;
      end
      S_CELL: begin
        if (cell_inb) begin
          probe_addr_nxt = {cmd_r.qy, cmd_r.qx};
          state_nxt      = S_P0;
        end else begin
          res_n_nxt       = 3'd1;
          res_found_nxt   = 1'b0;
          res_node_nxt[0] = '0;
          res_x_nxt       = '0;
          res_y_nxt       = '0;
          res_ovf_nxt     = 1'b0;
          state_nxt       = S_EMIT;
        end
      end
      S_NODE: begin
        res_n_nxt   = 3'd1;
        res_ovf_nxt = 1'b0;
        if ({1'b0, cmd_r.node} >= node_count_r) begin
          res_found_nxt   = 1'b0;
          res_node_nxt[0] = '0;
          res_x_nxt       = '0;
          res_y_nxt       = '0;
          state_nxt       = S_EMIT;
        end else begin
          state_nxt = S_COORD;
        end
      end
      S_COORD: begin
        if (cmd_r.req == REQ_COORD) begin
          res_found_nxt   = 1'b1;
          res_node_nxt[0] = cmd_r.node;
          res_x_nxt       = con_q[SIDE_W-1:0];
          res_y_nxt       = con_q[CELL_W-1:SIDE_W];
          state_nxt       = S_EMIT;
        end else begin
          cx_nxt    = con_q[SIDE_W-1:0];
          cy_nxt    = con_q[CELL_W-1:SIDE_W];
          k_nxt     = 2'd0;
          hits_nxt  = 3'd0;
          state_nxt = S_NBR;
        end
      end
      S_NBR: begin
        if (nbr_inb) begin
          probe_addr_nxt = {ny[SIDE_W-1:0], nx[SIDE_W-1:0]};
          state_nxt      = S_P0;
        end else begin
          nbr_adv = 1'b1;
        end
      end
      S_P0: begin
        state_nxt = S_P1;
      end
      S_P1: begin
        pass_nxt     = fm_q && ({1'b0, noc_q} < node_count_r);
        probe_id_nxt = noc_q;
        state_nxt    = S_P2;
      end
      S_P2: begin
        if (cmd_r.req == REQ_CELL) begin
          res_n_nxt       = 3'd1;
          res_found_nxt   = hit;
          res_node_nxt[0] = hit ? probe_id_r : '0;
          res_x_nxt       = '0;
          res_y_nxt       = '0;
          res_ovf_nxt     = 1'b0;
          state_nxt       = S_EMIT;
        end else begin
          if (hit) begin
            res_node_nxt[hits_r[1:0]] = probe_id_r;
            hits_cnt                  = hits_r + 3'd1;
            hits_nxt                  = hits_cnt;
          end
          nbr_adv = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_y_r, res_x_r, res_node_r[emit_idx_r]};
          out_user_nxt  = {res_ovf_r, res_found_r};
          out_last_nxt  = emit_last;
          if (emit_last) begin
            emit_idx_nxt = 2'd0;
            state_nxt    = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (nbr_adv) begin
      if (k_r == 2'd3) begin
        res_x_nxt   = '0;
        res_y_nxt   = '0;
        res_ovf_nxt = 1'b0;
        if (hits_cnt == 3'd0) begin
          res_n_nxt       = 3'd1;
          res_found_nxt   = 1'b0;
          res_node_nxt[0] = '0;
        end else begin
          res_n_nxt     = hits_cnt;
          res_found_nxt = 1'b1;
        end
        state_nxt = S_EMIT;
      end else begin
        k_nxt     = k_r + 2'd1;
        state_nxt = S_NBR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      node_count_r <= '0;
      load_x_r     <= '0;
      load_y_r     <= '0;
      emit_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      node_count_r <= node_count_nxt;
      load_x_r     <= load_x_nxt;
      load_y_r     <= load_y_nxt;
      emit_idx_r   <= emit_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    k_r          <= k_nxt;
    probe_addr_r <= probe_addr_nxt;
    pass_r       <= pass_nxt;
    probe_id_r   <= probe_id_nxt;
    hits_r       <= hits_nxt;
    res_node_r   <= res_node_nxt;
    res_n_r      <= res_n_nxt;
    res_found_r  <= res_found_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    res_ovf_r    <= res_ovf_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// ===== rtl/grid_cell_compaction_neighbors_unit.sv =====
// Occupancy grid to 4-connected node graph: load cells in raster order, then query ids,
// coordinates and free neighbors. After reset the unit sweeps its free-cell map with
// in_tready low; configuration writes are taken during the sweep. A front queue of two
// requests accepts input while the back end works. Back-end steps are set by the single
// read port of each table and the registered read data: a coordinate query reads the
// id-to-cell table, and a neighbor query then probes each neighbor inside the grid in turn
// through the free map, the cell-to-id table and the id-to-cell table, as a cell query
// probes its cell; a neighbor outside the grid is not probed. A cell outside the grid or
// an id not yet assigned answers without a probe. A grid_start load restarts numbering at
// once. Within an answer one result leaves per cycle while out_tready is high; a stalled
// result holds the back end.
module grid_cell_compaction_neighbors_unit
  import gccn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cell_blocked[0], query_x[6:1], query_y[12:7], query_node[24:13], zero[31:25]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0], grid_start[2]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // node_out[11:0], x_out[17:12], y_out[23:18]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // found[0], overflow[1]
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  logic [DIM_W-1:0] grid_width_r, grid_width_nxt;
  logic [DIM_W-1:0] grid_height_r, grid_height_nxt;
  logic [DIM_W-1:0] grid_w, grid_h;
  logic             clearing;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_wr_en) begin
      if (cfg_addr == REG_GRID_WIDTH) begin
        grid_width_nxt = cfg_wdata;
      end else if (cfg_addr == REG_GRID_HEIGHT) begin
        grid_height_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(MAX_SIDE);
      grid_height_r <= DIM_W'(MAX_SIDE);
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  assign grid_w = eff_dim(grid_width_r);
  assign grid_h = eff_dim(grid_height_r);

  gccn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (clearing),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  gccn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .grid_w     (grid_w),
    .grid_h     (grid_h),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/gccn_checker.sv =====
// Port-level checks on the result stream of the grid compaction unit, bound to the top level.
`include "grid_cell_compaction_neighbors_unit_assert.svh"

module gccn_checker
  import gccn_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tlast
);

  `GCCN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")
  `GCCN_ASSERT_NOW(a_miss_is_last, out_tvalid && !out_tuser[0], out_tlast, "miss result not last")
  `GCCN_ASSERT_NOW(a_ovf_no_found, out_tvalid && out_tuser[1], !out_tuser[0], "overflow with found")
  `GCCN_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tuser[0], out_tdata == '0, "miss result carries data")

endmodule

bind grid_cell_compaction_neighbors_unit gccn_checker u_gccn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/tb_top.sv =====
// Testbench for the grid compaction unit: directed and random grids checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import gccn_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 32;
  localparam int NBR_DX [NBR_MAX] = '{1, -1, 0, 0};
  localparam int NBR_DY [NBR_MAX] = '{0, 0, 1, -1};

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] node;
    logic [SIDE_W-1:0] x;
    logic [SIDE_W-1:0] y;
    logic              overflow;
    logic              last;
  } grid_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [DIM_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // cell_blocked[0], query_x[6:1], query_y[12:7], query_node[24:13], zero[31:25]
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // req_type[1:0], grid_start[2]
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // node_out[11:0], x_out[17:12], y_out[23:18]
  logic [OUT_DATA_W-1:0] out_tdata;
  // found[0], overflow[1]
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  grid_result_t pending_results[$];

  // predictor state
  logic [DIM_W-1:0]  grid_w_q;
  logic [DIM_W-1:0]  grid_h_q;
  bit                cell_free  [CELLS];
  logic [NODE_W-1:0] id_of_cell [CELLS];
  logic [CELL_W-1:0] cell_of_id [MAX_NODES];
  logic [CNT_W-1:0]  node_total;
  logic [SIDE_W-1:0] load_col;
  logic [DIM_W-1:0]  load_row;

  grid_cell_compaction_neighbors_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= 100)
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin : check_result
    grid_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending",
                        32'({out_tlast, out_tuser, out_tdata}), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.found)
          report_mismatch("found", 32'(out_tuser[0]), 32'(want.found));
        if (out_tdata[11:0] !== want.node)
          report_mismatch("node_out", 32'(out_tdata[11:0]), 32'(want.node));
        if (out_tdata[17:12] !== want.x)
          report_mismatch("x_out", 32'(out_tdata[17:12]), 32'(want.x));
        if (out_tdata[23:18] !== want.y)
          report_mismatch("y_out", 32'(out_tdata[23:18]), 32'(want.y));
        if (out_tuser[1] !== want.overflow)
          report_mismatch("overflow", 32'(out_tuser[1]), 32'(want.overflow));
        if (out_tlast !== want.last)
          report_mismatch("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  function automatic int clamp_side(input logic [DIM_W-1:0] r);
    return (int'(r) > MAX_SIDE) ? MAX_SIDE : int'(r);
  endfunction

  function automatic bit free_id_at(input int x, input int y, output logic [NODE_W-1:0] id);
    int cell_idx;
    id = '0;
    if (x < 0 || y < 0 || x >= clamp_side(grid_w_q) || y >= clamp_side(grid_h_q))
      return 1'b0;
    cell_idx = y * MAX_SIDE + x;
    if (!cell_free[cell_idx])
      return 1'b0;
    id = id_of_cell[cell_idx];
    return 1'b1;
  endfunction

  task automatic push_result(input logic found, input logic [NODE_W-1:0] node,
                             input logic [SIDE_W-1:0] x, input logic [SIDE_W-1:0] y,
                             input logic overflow, input logic last);
    grid_result_t r;
    r.found    = found;
    r.node     = node;
    r.x        = x;
    r.y        = y;
    r.overflow = overflow;
    r.last     = last;
    pending_results = {pending_results, r};
  endtask

  task automatic predict_request(input cmd_t c);
    int w, h, cell_idx, cx, cy, hits;
    logic [NODE_W-1:0] nid;
    logic [NODE_W-1:0] nbr_ids [NBR_MAX];
    w = clamp_side(grid_w_q);
    h = clamp_side(grid_h_q);
    hits = 0;
    if (c.req == REQ_LOAD) begin
      if (c.start) begin
        foreach (cell_free[i]) cell_free[i] = 1'b0;
        node_total = '0;
        load_col   = '0;
        load_row   = '0;
      end
      if (int'(load_col) >= w || int'(load_row) >= h) begin
        push_result(1'b0, '0, '0, '0, 1'b1, 1'b1);
      end else begin
        cell_idx = int'(load_row) * MAX_SIDE + int'(load_col);
        if (c.blocked) begin
          push_result(1'b0, '0, '0, '0, 1'b0, 1'b1);
        end else if (int'(node_total) < MAX_NODES) begin
          nid = node_total[NODE_W-1:0];
          cell_free[cell_idx]  = 1'b1;
          id_of_cell[cell_idx] = nid;
          cell_of_id[nid]      = CELL_W'(cell_idx);
          node_total++;
          push_result(1'b1, nid, '0, '0, 1'b0, 1'b1);
        end else begin
          push_result(1'b0, '0, '0, '0, 1'b1, 1'b1);
        end
        if (int'(load_col) + 1 >= w) begin
          load_col = '0;
          load_row++;
        end else begin
          load_col++;
        end
      end
    end else if (c.req == REQ_CELL) begin
      if (free_id_at(int'(c.qx), int'(c.qy), nid))
        push_result(1'b1, nid, '0, '0, 1'b0, 1'b1);
      else
        push_result(1'b0, '0, '0, '0, 1'b0, 1'b1);
    end else if (CNT_W'(c.node) >= node_total) begin
      push_result(1'b0, '0, '0, '0, 1'b0, 1'b1);
    end else begin
      cell_idx = int'(cell_of_id[c.node]);
      cx = cell_idx % MAX_SIDE;
      cy = cell_idx / MAX_SIDE;
      if (c.req == REQ_COORD) begin
        push_result(1'b1, c.node, SIDE_W'(cx), SIDE_W'(cy), 1'b0, 1'b1);
      end else begin
        for (int k = 0; k < NBR_MAX; k++)
          if (free_id_at(cx + NBR_DX[k], cy + NBR_DY[k], nid)) begin
            nbr_ids[hits] = nid;
            hits++;
          end
        if (hits == 0)
          push_result(1'b0, '0, '0, '0, 1'b0, 1'b1);
        for (int k = 0; k < hits; k++)
          push_result(1'b1, nbr_ids[k], '0, '0, 1'b0, k == hits - 1);
      end
    end
  endtask

  task automatic send_request(input cmd_t c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, c.node, c.qy, c.qx, c.blocked};
    in_tuser  <= {c.start, c.req};
    do @(posedge clk); while (!in_tready);
    predict_request(c);
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.req     = 2'($urandom_range(3));
    c.start   = 1'($urandom_range(1));
    c.blocked = 1'($urandom_range(1));
    c.qx      = SIDE_W'($urandom_range(63));
    c.qy      = SIDE_W'($urandom_range(63));
    c.node    = NODE_W'($urandom_range(MAX_NODES - 1));
    return c;
  endfunction

  task automatic load_cell(input logic start, input logic blocked);
    cmd_t c;
    c = random_cmd();
    c.req     = REQ_LOAD;
    c.start   = start;
    c.blocked = blocked;
    send_request(c);
  endtask

  task automatic ask_cell(input int x, input int y);
    cmd_t c;
    c = random_cmd();
    c.req = REQ_CELL;
    c.qx  = SIDE_W'(x);
    c.qy  = SIDE_W'(y);
    send_request(c);
  endtask

  task automatic ask_node(input logic [1:0] req, input int node);
    cmd_t c;
    c = random_cmd();
    c.req  = req;
    c.node = NODE_W'(node);
    send_request(c);
  endtask

  // drop valid and hold until every pending result has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic reconfigure_grid(input int w, input int h);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_GRID_WIDTH;
    cfg_wdata <= DIM_W'(w);
    @(posedge clk);
    grid_w_q = DIM_W'(w);
    cfg_addr  <= REG_GRID_HEIGHT;
    cfg_wdata <= DIM_W'(h);
    @(posedge clk);
    grid_h_q = DIM_W'(h);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_small_grid();
    logic [11:0] blocked_mask;
    blocked_mask = 12'h584;
    reconfigure_grid(4, 3);
    for (int i = 0; i < 12; i++) load_cell(i == 0, blocked_mask[i]);
    load_cell(1'b0, 1'b0);
    ask_cell(3, 2);
    ask_cell(2, 2);
    ask_cell(0, 0);
    ask_cell(4, 0);
    ask_cell(63, 63);
    ask_node(REQ_COORD, 7);
    ask_node(REQ_COORD, 8);
    ask_node(REQ_COORD, 4095);
    ask_node(REQ_NBR, 4);
    ask_node(REQ_NBR, 2);
    ask_node(REQ_NBR, 8);
  endtask

  task automatic test_resized_bounds();
    reconfigure_grid(2, 3);
    ask_node(REQ_NBR, 4);
    ask_cell(3, 0);
    ask_node(REQ_COORD, 2);
    load_cell(1'b0, 1'b0);
    reconfigure_grid(0, 3);
    ask_node(REQ_NBR, 0);
    ask_node(REQ_COORD, 0);
  endtask

  task automatic test_degenerate_dims();
    reconfigure_grid(127, 0);
    load_cell(1'b1, 1'b0);
    ask_cell(0, 0);
    reconfigure_grid(127, 1);
    load_cell(1'b1, 1'b0);
    load_cell(1'b0, 1'b1);
    load_cell(1'b0, 1'b0);
    load_cell(1'b0, 1'b0);
    ask_node(REQ_NBR, 1);
    ask_cell(63, 0);
    ask_cell(0, 1);
  endtask

  task automatic test_random_graphs(input int idle_pct, input int stall_pct);
    int w, h;
    cmd_t c;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if ($urandom_range(7) == 0) begin
      w = $urandom_range(64, 9);
      h = 1;
    end else begin
      w = $urandom_range(5, 1);
      h = $urandom_range(5, 1);
    end
    reconfigure_grid(w, h);
    for (int i = 0; i < w * h; i++)
      load_cell(i == 0 || $urandom_range(39) == 0, $urandom_range(99) < 30);
    repeat ($urandom_range(2)) load_cell(1'b0, 1'($urandom_range(1)));
    repeat (10) begin
      c = random_cmd();
      if ($urandom_range(9) != 0) begin
        c.req   = 2'($urandom_range(3, 1));
        c.start = 1'b0;
        if ($urandom_range(3) != 0) begin
          c.qx   = SIDE_W'($urandom_range(w));
          c.qy   = SIDE_W'($urandom_range(h));
          c.node = NODE_W'($urandom_range(int'(node_total)));
        end
      end
      send_request(c);
    end
  endtask

  initial begin
    grid_w_q   = DIM_W'(MAX_SIDE);
    grid_h_q   = DIM_W'(MAX_SIDE);
    node_total = '0;
    load_col   = '0;
    load_row   = '0;
    foreach (cell_free[i]) cell_free[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_small_grid();
    test_resized_bounds();
    test_degenerate_dims();
    test_random_graphs(0, 0);
    test_random_graphs(73, 0);
    test_random_graphs(0, 73);
    test_random_graphs(17, 17);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results left pending", pending_results.size(), 0);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
